/* hdl/prs_pkg.sv */
// ----------------------------------------------------------------------------
// prs_pkg
// Shared widths, codes and types for the price record sorter.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int PRICE_W     = 32;
  localparam int TAG_W       = 6;
  localparam int MODE_W      = 2;

  // Sort order codes held in the configuration register
  localparam logic [MODE_W-1:0] MODE_KEEP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd2;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_HOLD,
    S_INNER,
    S_WB,
    S_EMIT_RD,
    S_EMIT
  } prs_state_t;

  // True when the pair (a at the lower index, b at the higher) must swap
  function automatic logic out_of_order(input logic [MODE_W-1:0]  mode,
                                        input logic [PRICE_W-1:0] a,
                                        input logic [PRICE_W-1:0] b);
    logic res;
    res = 1'b0;
    case (mode)
      MODE_ASC:  res = (a > b);
      MODE_DESC: res = (a < b);
      default:   res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/price_record_sorter_core.sv */
// ----------------------------------------------------------------------------
// price_record_sorter_core
// Loads a list of price records, exchange-sorts it in place and emits it.
// ----------------------------------------------------------------------------
// Records enter one per cycle and are written to a 64-entry record memory;
// records beyond 64 are dropped, but an is_last flag on a dropped record still
// closes the list. On the item marked last the block stops taking input and
// runs an exchange sort in the memory (order_mode: 0 keep, 1 ascending,
// 2 descending; 3 behaves as 0), checking the mode at that moment and reading
// the mode register again at every compare. The entry at the outer index is
// held in a register while the inner index walks the memory one entry per
// cycle, one read and at most one write each cycle. No sort runs for a list
// of fewer than two records or when no order is selected. The records are
// then streamed out one per cycle when the output is not stalled, the final
// one flagged by out_last_out; the input is taken again from the cycle after
// the final item leaves the memory, while that item may still sit in the
// output register. Configuration is always ready; write it only while the
// block is idle.
// ----------------------------------------------------------------------------
module price_record_sorter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [prs_pkg::MODE_W-1:0]  cfg_order_mode,
  // record input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [prs_pkg::PRICE_W-1:0] in_price,
  input  logic [prs_pkg::TAG_W-1:0]   in_record_tag,
  input  logic                        in_is_last,
  // sorted record output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [prs_pkg::PRICE_W-1:0] out_sorted_price,
  output logic [prs_pkg::TAG_W-1:0]   out_sorted_tag,
  output logic                        out_last_out
);
  import prs_pkg::*;

  // Record memory: one write port, one registered read port
  rec_t mem [MAX_RECORDS];
  rec_t rd_data_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rec_t              wr_data;
  logic [ADDR_W-1:0] rd_addr;

  prs_state_t state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  rec_t              hold_r, hold_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PRICE_W-1:0] out_price_r, out_price_nxt;
  logic [TAG_W-1:0]   out_tag_r, out_tag_nxt;
  logic               out_last_r, out_last_nxt;

  logic [ADDR_W-1:0] last_idx;
  logic [CNT_W-1:0]  cnt_after;
  logic              room;
  logic              out_free;

  assign cfg_ready        = 1'b1;
  assign in_stall         = (state_r != S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_price = out_price_r;
  assign out_sorted_tag   = out_tag_r;
  assign out_last_out     = out_last_r;

  // Highest occupied index of the current list (list never empty once closed)
  assign last_idx  = ADDR_W'(cnt_r - 1'b1);
  assign room      = (cnt_r < CNT_W'(MAX_RECORDS));
  assign cnt_after = room ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mode_r      <= MODE_ASC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_order_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    hold_r      <= hold_nxt;
    out_price_r <= out_price_nxt;
    out_tag_r   <= out_tag_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Sequencer: load, sort in place, emit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_price_nxt = out_price_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = i_r;
    wr_data       = hold_r;
    rd_addr       = i_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          // store while there is room, drop otherwise
          if (room) begin
            wr_en         = 1'b1;
            wr_addr       = cnt_r[ADDR_W-1:0];
            wr_data.price = in_price;
            wr_data.tag   = in_record_tag;
          end
          cnt_nxt = cnt_after;
          if (in_is_last) begin
            i_nxt = '0;
            k_nxt = '0;
            if ((cnt_after > CNT_W'(1)) && (mode_r == MODE_ASC || mode_r == MODE_DESC)) begin
              state_nxt = S_OUTER;
            end else begin
              state_nxt = S_EMIT_RD;
            end
          end
        end
      end

      S_OUTER: begin
        rd_addr   = i_r;
        state_nxt = S_HOLD;
      end

      S_HOLD: begin
        // capture entry i, fetch first partner
        hold_nxt  = rd_data_r;
        rd_addr   = ADDR_W'(i_r + 1'b1);
        j_nxt     = ADDR_W'(i_r + 1'b1);
        state_nxt = S_INNER;
      end

      S_INNER: begin
        if (out_of_order(mode_r, hold_r.price, rd_data_r.price)) begin
          wr_en    = 1'b1;
          wr_addr  = j_r;
          wr_data  = hold_r;
          hold_nxt = rd_data_r;
        end
        if (j_r == last_idx) begin
          state_nxt = S_WB;
        end else begin
          j_nxt   = ADDR_W'(j_r + 1'b1);
          rd_addr = ADDR_W'(j_r + 1'b1);
        end
      end

      S_WB: begin
        // write back entry i, advance the outer index
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = hold_r;
        if (ADDR_W'(i_r + 1'b1) == last_idx) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          i_nxt     = ADDR_W'(i_r + 1'b1);
          rd_addr   = ADDR_W'(i_r + 1'b1);
          state_nxt = S_HOLD;
        end
      end

      S_EMIT_RD: begin
        rd_addr   = k_r;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // hold the read address while the output is blocked
        rd_addr = k_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_price_nxt = rd_data_r.price;
          out_tag_nxt   = rd_data_r.tag;
          out_last_nxt  = (k_r == last_idx);
          if (k_r == last_idx) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt   = ADDR_W'(k_r + 1'b1);
            rd_addr = ADDR_W'(k_r + 1'b1);
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for price_record_sorter_core.
// ----------------------------------------------------------------------------
// Record lists are queued by the stimulus process and fed to the block by a
// driver on the falling edge. A monitor on the rising edge sees each item
// taken by the block and updates an in-bench copy of the sorter. When an
// item ends a list, the monitor sorts that copy and queues the expected
// output run. Each sorted item that leaves the block is checked field by
// field against the oldest expected one. All order modes are covered,
// including the unused code. So are equal prices, full lists with dropped
// records and single-record lists. Sender gaps and output stalls vary by
// phase.
// ----------------------------------------------------------------------------
module testbench;
  import prs_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;      // settle time after the final item has left
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 20000;  // far beyond the longest full-list sort
  localparam int REPORT_LIMIT   = 100;
  localparam int SEGMENT_ITEMS  = 40;

  // Mode code 3 is unused by the block and must behave as keep-order
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } price_rec_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [MODE_W-1:0]  cfg_order_mode = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [PRICE_W-1:0] in_price       = '0;
  logic [TAG_W-1:0]   in_record_tag  = '0;
  logic               in_is_last     = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [PRICE_W-1:0] out_sorted_price;
  logic [TAG_W-1:0]   out_sorted_tag;
  logic               out_last_out;

  price_record_sorter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_order_mode   (cfg_order_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_price         (in_price),
    .in_record_tag    (in_record_tag),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_price (out_sorted_price),
    .out_sorted_tag   (out_sorted_tag),
    .out_last_out     (out_last_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  price_rec_t         pending_records_q[$];   // items still to be sent
  price_rec_t         expected_sorted_q[$];   // sorted items still to arrive
  int                 send_idle_pct = 34;     // sender gap chance, per cent
  int                 recv_idle_pct = 70;     // output stall chance, per cent
  logic               record_taken  = 1'b0;   // item taken at the last rising edge
  int                 quiet_cycles  = 0;
  int                 mismatch_count = 0;

  // Mirror of the block: mode register and the record memory of the open list
  logic [MODE_W-1:0]  mirror_mode = MODE_ASC;
  logic [PRICE_W-1:0] mirror_price[MAX_RECORDS];
  logic [TAG_W-1:0]   mirror_tag[MAX_RECORDS];
  int                 mirror_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Store one taken item; on the closing item, exchange-sort the list and
  // queue the whole sorted run as expected output.
  task automatic predict_sorted_run(input logic [PRICE_W-1:0] price,
                                    input logic [TAG_W-1:0]   tag,
                                    input logic               last);
    logic [PRICE_W-1:0] held_price;
    logic [TAG_W-1:0]   held_tag;
    logic               swap;
    price_rec_t         run_rec;
    // drop records once the list is full; a dropped is_last still closes it
    if (mirror_count < MAX_RECORDS) begin
      mirror_price[mirror_count] = price;
      mirror_tag[mirror_count]   = tag;
      mirror_count++;
    end
    if (last) begin
      for (int i = 0; i + 1 < mirror_count; i++) begin
        for (int j = i + 1; j < mirror_count; j++) begin
          // strict compare only: equal prices never swap
          swap = (mirror_mode == MODE_ASC  && mirror_price[i] > mirror_price[j]) ||
                 (mirror_mode == MODE_DESC && mirror_price[i] < mirror_price[j]);
          if (swap) begin
            held_price      = mirror_price[i];
            held_tag        = mirror_tag[i];
            mirror_price[i] = mirror_price[j];
            mirror_tag[i]   = mirror_tag[j];
            mirror_price[j] = held_price;
            mirror_tag[j]   = held_tag;
          end
        end
      end
      for (int k = 0; k < mirror_count; k++) begin
        run_rec.price = mirror_price[k];
        run_rec.tag   = mirror_tag[k];
        run_rec.last  = (k == mirror_count - 1);
        expected_sorted_q.push_back(run_rec);
      end
      mirror_count = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present items and stalls on the falling edge.
  // Hold a stalled item; advance only after the monitor saw it taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : record_driver
    price_rec_t next_rec;
    if (!in_valid || record_taken) begin
      if (rst_n && pending_records_q.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        next_rec       = pending_records_q.pop_front();
        in_valid      <= 1'b1;
        in_price      <= next_rec.price;
        in_record_tag <= next_rec.tag;
        in_is_last    <= next_rec.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: sample all three channels on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    logic       cfg_hs;
    logic       rec_hs;
    logic       res_hs;
    price_rec_t want;
    cfg_hs = rst_n && cfg_valid && cfg_ready;
    rec_hs = rst_n && in_valid && !in_stall;
    res_hs = rst_n && out_valid && !out_stall;
    record_taken <= rec_hs;

    if (!rst_n) begin
      mirror_mode  = MODE_ASC;
      mirror_count = 0;
    end
    if (cfg_hs)
      mirror_mode = cfg_order_mode;
    // predict before checking: a run can never leave on the edge that closes it
    if (rec_hs)
      predict_sorted_run(in_price, in_record_tag, in_is_last);
    if (res_hs) begin
      if (expected_sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item price %0h tag %0d last %0b",
                                  out_sorted_price, out_sorted_tag, out_last_out));
      end else begin
        want = expected_sorted_q.pop_front();
        if (out_sorted_price !== want.price)
          report_mismatch($sformatf("sorted_price %0h, want %0h",
                                    out_sorted_price, want.price));
        if (out_sorted_tag !== want.tag)
          report_mismatch($sformatf("sorted_tag %0d, want %0d",
                                    out_sorted_tag, want.tag));
        if (out_last_out !== want.last)
          report_mismatch($sformatf("last_out %0b, want %0b",
                                    out_last_out, want.last));
      end
    end

    if (cfg_hs || rec_hs || res_hs)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog: stop when nothing moves for far longer than the slowest sort
  always @(posedge clk) begin : watchdog
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_record(input logic [PRICE_W-1:0] price,
                             input logic [TAG_W-1:0]   tag,
                             input logic               last);
    price_rec_t rec;
    rec.price = price;
    rec.tag   = tag;
    rec.last  = last;
    pending_records_q.push_back(rec);
  endtask

  // Queue one list; prices lean towards a narrow range so that ties occur
  task automatic queue_random_list(input int len);
    int                 pick;
    logic [PRICE_W-1:0] price;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        price = $urandom_range(0, 7);
      else if (pick == 4)
        price = $urandom_range(0, 1) ? '1 : '0;
      else
        price = $urandom;
      push_record(price, TAG_W'($urandom_range(0, 63)), k == len - 1);
    end
  endtask

  // Pause the sender until every expected item has come out, then let the
  // block settle back to loading
  task automatic wait_for_drain();
    do
      @(posedge clk);
    while (pending_records_q.size() != 0 || in_valid || expected_sorted_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order_mode(input logic [MODE_W-1:0] mode);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_order_mode <= mode;
    do
      @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [MODE_W-1:0] seg_mode;
    int                queued;
    int                len;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ascending from reset, price extremes and ties
    push_record('1,            6'd63, 1'b0);
    push_record('0,            6'd0,  1'b0);
    push_record(32'd5,         6'd1,  1'b0);
    push_record(32'd5,         6'd2,  1'b0);
    push_record('1,            6'd62, 1'b0);
    push_record(32'd1,         6'd3,  1'b1);
    // single-record list
    push_record(32'd7,         6'd10, 1'b1);
    wait_for_drain();

    write_order_mode(MODE_DESC);
    push_record('0,            6'd5,  1'b0);
    push_record('1,            6'd6,  1'b0);
    push_record(32'd3,         6'd7,  1'b0);
    push_record(32'd3,         6'd8,  1'b0);
    push_record(32'h8000_0000, 6'd9,  1'b1);
    wait_for_drain();

    write_order_mode(MODE_KEEP);
    push_record(32'd9,         6'd11, 1'b0);
    push_record(32'd2,         6'd12, 1'b0);
    push_record('1,            6'd13, 1'b0);
    push_record('0,            6'd14, 1'b1);
    wait_for_drain();

    // unused code: expect load order back
    write_order_mode(MODE_UNUSED);
    push_record(32'd4,         6'd20, 1'b0);
    push_record(32'd1,         6'd21, 1'b0);
    push_record(32'd8,         6'd22, 1'b0);
    push_record(32'd1,         6'd23, 1'b1);
    wait_for_drain();

    // Random: six segments, one mode each; swap idling from segment 2, none from segment 4
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 70;
        recv_idle_pct = 34;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       seg_mode = MODE_KEEP;
        1:       seg_mode = MODE_ASC;
        2:       seg_mode = MODE_DESC;
        3:       seg_mode = MODE_UNUSED;
        4:       seg_mode = MODE_DESC;
        default: seg_mode = MODE_W'($urandom_range(0, 3));
      endcase
      write_order_mode(seg_mode);

      // overflow: records past the limit are dropped, the dropped last one
      // still closes the list
      if (seg == 1)
        queue_random_list(MAX_RECORDS + 6);
      // exactly full list, worst-case sort
      if (seg == 4)
        queue_random_list(MAX_RECORDS);

      queued = 0;
      while (queued < SEGMENT_ITEMS) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
        queue_random_list(len);
        queued += len;
      end
      wait_for_drain();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
